>>> sv/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types, request codes and constants of the xoshiro256++ generator
// with splitmix64 seeding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xrg_pkg;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_SEED    = 2'd0;
   localparam logic [1:0] REQ_RAW     = 2'd1;
   localparam logic [1:0] REQ_BOUNDED = 2'd2;
   localparam logic [1:0] REQ_FRAC    = 2'd3;

   // Splitmix64 constants.
   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;
   localparam int unsigned MIX_SHIFT_A  = 30;
   localparam int unsigned MIX_SHIFT_B  = 27;
   localparam int unsigned MIX_SHIFT_C  = 31;

   // Xoshiro256++ constants.
   localparam int unsigned ROT_OUT   = 23;
   localparam int unsigned SHIFT_T   = 17;
   localparam int unsigned ROT_STATE = 45;
   localparam int unsigned FRAC_DROP = 11;

   // Default depth of the request queue between front and back.
   localparam int unsigned XRG_QUEUE_DEPTH = 4;

   // A classified request as it sits in the queue.
   typedef struct packed {
      logic        is_seed;
      logic [1:0]  kind;
      logic [63:0] seed_value;
      logic [31:0] bound;
   } cmd_type;

   // Back end to seeder: start a seeding run, or take its finished result.
   typedef struct packed {
      logic        start;
      logic [63:0] seed;
      logic        ack;
   } seed_ctl_type;

   // Seeder to back end: status and the state-word write port.
   typedef struct packed {
      logic        busy;
      logic        report;
      logic        wr_en;
      logic [1:0]  wr_idx;
      logic [63:0] wr_data;
   } seed_sts_type;

   // Left rotation by a nonzero amount below 64.
   function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned k);
      rot_left = (v << k) | (v >> (64 - k));
   endfunction

endpackage

>>> sv/xrg_front.sv
// ----------------------------------------------------------------------------
// xrg_front
// Accepts requests, classifies them and holds them in a short queue that
// the back end drains at its own pace.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xrg_front
   import xrg_pkg::*;
#(
   parameter int unsigned DEPTH = XRG_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_seed_value,
   input  logic [31:0] req_bound,
   output logic        head_valid,
   output cmd_type     head,
   input  logic        pop
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type            queue_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   cmd_type            cmd;

   // Classify the incoming request.
   always_comb begin
      cmd.is_seed    = (req_type == REQ_SEED);
      cmd.kind       = req_type;
      cmd.seed_value = req_seed_value;
      cmd.bound      = req_bound;
   end

   // Handshake: a transfer happens whenever the queue has room.
   assign req_stall  = (count_ff == CNT_W'(DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

`ifndef ASSERT_OFF
   // The back end only takes an entry that is there.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue popped while empty");
`endif

endmodule

>>> sv/xrg_seeder.sv
// ----------------------------------------------------------------------------
// xrg_seeder
// Splitmix64 sequencer that fills the four state words from a seed. One
// shared 32x32 multiplier forms each 64-bit product from three partial
// products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xrg_seeder
   import xrg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  seed_ctl_type ctl,
   output seed_sts_type sts
);

   localparam logic [1:0] SQ_IDLE = 2'd0;
   localparam logic [1:0] SQ_MIX  = 2'd1;
   localparam logic [1:0] SQ_DONE = 2'd2;

   // Reset runs the sequence for seed zero.
   localparam logic [63:0] RESET_Z = GOLDEN_GAMMA;
   localparam logic [63:0] RESET_M = GOLDEN_GAMMA ^ (GOLDEN_GAMMA >> MIX_SHIFT_A);

   logic [1:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic        sel_ff, sel_in;
   logic [1:0]  idx_ff, idx_in;
   logic        report_ff, report_in;
   logic [63:0] z_ff, z_in;
   logic [63:0] m_ff, m_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] mul_const;
   logic [31:0] op_a, op_b;
   logic [63:0] fin;
   logic [63:0] z_next;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_const = sel_ff ? MIX_MUL_B : MIX_MUL_A;
      unique case (phase_ff)
         2'd1: begin
            op_a = m_ff[63:32];
            op_b = mul_const[31:0];
         end
         2'd2: begin
            op_a = m_ff[31:0];
            op_b = mul_const[63:32];
         end
         default: begin
            op_a = m_ff[31:0];
            op_b = mul_const[31:0];
         end
      endcase
      prod_in = {32'd0, op_a} * {32'd0, op_b};
   end

   // Final product and the next splitmix counter value.
   assign fin    = acc_ff + {prod_ff[31:0], 32'd0};
   assign z_next = z_ff + GOLDEN_GAMMA;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      sel_in    = sel_ff;
      idx_in    = idx_ff;
      report_in = report_ff;
      z_in      = z_ff;
      m_in      = m_ff;
      acc_in    = acc_ff;
      unique case (state_ff)
         SQ_IDLE: begin
            if (ctl.start) begin
               z_in      = ctl.seed + GOLDEN_GAMMA;
               m_in      = z_in ^ (z_in >> MIX_SHIFT_A);
               state_in  = SQ_MIX;
               phase_in  = 2'd0;
               sel_in    = 1'b0;
               idx_in    = 2'd0;
               report_in = 1'b1;
            end
         end
         SQ_MIX: begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: acc_in = acc_ff;
               2'd1: acc_in = prod_ff;
               2'd2: acc_in = fin;
               default: begin
                  if (!sel_ff) begin
                     m_in   = fin ^ (fin >> MIX_SHIFT_B);
                     sel_in = 1'b1;
                  end else if (idx_ff == 2'd3) begin
                     state_in = report_ff ? SQ_DONE : SQ_IDLE;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                     z_in   = z_next;
                     m_in   = z_next ^ (z_next >> MIX_SHIFT_A);
                     sel_in = 1'b0;
                  end
               end
            endcase
         end
         SQ_DONE: begin
            if (ctl.ack) begin
               state_in  = SQ_IDLE;
               report_in = 1'b0;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SQ_MIX;
         phase_ff  <= 2'd0;
         sel_ff    <= 1'b0;
         idx_ff    <= 2'd0;
         report_ff <= 1'b0;
         z_ff      <= RESET_Z;
         m_ff      <= RESET_M;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         sel_ff    <= sel_in;
         idx_ff    <= idx_in;
         report_ff <= report_in;
         z_ff      <= z_in;
         m_ff      <= m_in;
      end
   end

   // Datapath registers of the multiplication.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   // Status and the state-word write port.
   always_comb begin
      sts.busy    = (state_ff != SQ_IDLE);
      sts.report  = (state_ff == SQ_DONE);
      sts.wr_en   = (state_ff == SQ_MIX) && (phase_ff == 2'd3) && sel_ff;
      sts.wr_idx  = idx_ff;
      sts.wr_data = fin ^ (fin >> MIX_SHIFT_C);
   end

`ifndef ASSERT_OFF
   // A new seeding run starts only when the previous one is finished.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == SQ_IDLE))
      else $error("seeding started while busy");
`endif

endmodule

>>> sv/xrg_back.sv
// ----------------------------------------------------------------------------
// xrg_back
// Holds the four state words, issues draws from the queue and runs them
// through a three-stage result pipeline: sum, rotate and add, finish.
// Seed requests are handed to the seeder and answer zero when it is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xrg_back
   import xrg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head,
   output logic         pop,
   output seed_ctl_type ctl,
   input  seed_sts_type sts,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_value
);

   logic [63:0] gen_ff [4];
   logic [63:0] gen_in [4];
   logic        advance;
   logic        issue_draw;
   logic        inject_seed;
   logic [63:0] t_word;
   logic [63:0] mix2, mix3;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff, s1_kind_in;
   logic [63:0] s1_sum_ff;
   logic [63:0] s1_w0_ff;
   logic [31:0] s1_bound_ff;

   logic        s2_valid_ff;
   logic [1:0]  s2_kind_ff;
   logic [63:0] s2_r_ff;
   logic [31:0] s2_bound_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic [63:0] bnd_prod;

   // The pipeline moves whenever the output register is free or drained.
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign issue_draw  = head_valid && !head.is_seed && !sts.busy && advance;
   assign inject_seed = sts.report && advance;

   // Seeder control.
   always_comb begin
      ctl.start = head_valid && head.is_seed && !sts.busy;
      ctl.seed  = head.seed_value;
      ctl.ack   = inject_seed;
   end

   assign pop = ctl.start || issue_draw;

   // Next state words: seeder writes, or one xoshiro256++ step.
   always_comb begin
      t_word = gen_ff[1] << SHIFT_T;
      mix2   = gen_ff[2] ^ gen_ff[0];
      mix3   = gen_ff[3] ^ gen_ff[1];
      for (int i = 0; i < 4; i++) begin
         gen_in[i] = gen_ff[i];
      end
      if (sts.wr_en) begin
         gen_in[sts.wr_idx] = sts.wr_data;
      end else if (issue_draw) begin
         gen_in[0] = gen_ff[0] ^ mix3;
         gen_in[1] = gen_ff[1] ^ mix2;
         gen_in[2] = mix2 ^ t_word;
         gen_in[3] = rot_left(mix3, ROT_STATE);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         gen_ff[i] <= gen_in[i];
      end
   end

   // First stage takes either a draw or the zero answer of a seed request.
   always_comb begin
      s1_valid_in = issue_draw || inject_seed;
      s1_kind_in  = inject_seed ? REQ_SEED : head.kind;
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline datapath.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff   <= s1_kind_in;
         s1_sum_ff    <= gen_ff[0] + gen_ff[3];
         s1_w0_ff     <= gen_ff[0];
         s1_bound_ff  <= head.bound;
         s2_kind_ff   <= s1_kind_ff;
         s2_r_ff      <= rot_left(s1_sum_ff, ROT_OUT) + s1_w0_ff;
         s2_bound_ff  <= s1_bound_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   // Final shaping of the draw.
   assign bnd_prod = {32'd0, s2_r_ff[63:32]} * {32'd0, s2_bound_ff};

   always_comb begin
      unique case (s2_kind_ff)
         REQ_SEED:    rsp_value_in = '0;
         REQ_RAW:     rsp_value_in = s2_r_ff;
         REQ_BOUNDED: rsp_value_in = {32'd0, bnd_prod[63:32]};
         REQ_FRAC:    rsp_value_in = s2_r_ff >> FRAC_DROP;
         default:     rsp_value_in = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

`ifndef ASSERT_OFF
   // Seeding and drawing never touch the state words in the same cycle.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      sts.wr_en |-> !issue_draw)
      else $error("seed write collides with a draw");

   // A bounded draw with a nonzero bound lands below that bound.
   a_bound_range: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && (s2_kind_ff == REQ_BOUNDED) && (s2_bound_ff != '0))
      |=> ((rsp_value_ff[63:32] == '0) && (rsp_value_ff[31:0] < $past(s2_bound_ff))))
      else $error("bounded draw out of range");
`endif

endmodule

>>> sv/xoshiro256pp_random_generator_core.sv
// A draw passes from the request queue through the sum, rotate-and-add and finish registers.
// Throughput: one draw per cycle while the output is not stalled and no seeding runs.
// A seed request runs 8 multiplications on the shared 32x32 multiplier,
// and no draw is issued meanwhile.
// Reset seeds the state with zero; requests queue up meanwhile.
// ----------------------------------------------------------------------------
// xoshiro256pp_random_generator_core
// Top level: request queue in front, seeder and draw pipeline in the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xoshiro256pp_random_generator_core
   import xrg_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = XRG_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_seed_value,
   input  logic [31:0] req_bound,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value
);

   logic         head_valid;
   cmd_type      head;
   logic         pop;
   seed_ctl_type seed_ctl;
   seed_sts_type seed_sts;

   // Request queue.
   xrg_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .req_bound      (req_bound),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop)
   );

   // Splitmix64 seeding sequencer.
   xrg_seeder u_seeder (
      .clock (clock),
      .reset (reset),
      .ctl   (seed_ctl),
      .sts   (seed_sts)
   );

   // State words and draw pipeline.
   xrg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .ctl        (seed_ctl),
      .sts        (seed_sts),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value)
   );

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the xoshiro256++ generator with splitmix64 seeding.
// A directed table covers the seed extremes, every request kind and the zero
// bound. A long random run follows, with idle and stall bursts on both
// channels. Each accepted request is run through a local model of the four
// state words, and every result transfer is checked against the oldest
// pending value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import xrg_pkg::*;

   localparam int unsigned RAND_COUNT = 800;
   localparam int unsigned CALM_COUNT = 100;
   localparam int unsigned DIR_COUNT  = 20;
   localparam int unsigned PRINT_CAP  = 40;

   // One row of the directed table. A row with a fixed value is checked
   // against that value; any other row is checked against the model.
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] seed;
      logic [31:0] bound;
      logic        fixed;
      logic [63:0] value;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_RAW;
   logic [63:0] req_seed_value = '0;
   logic [31:0] req_bound = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;

   // Travel with the request payload so the monitor sees them at the transfer.
   logic        row_fixed = 1'b0;
   logic [63:0] row_value = '0;

   // Enables idle and stall bursts; cleared in quiet stretches and at the end.
   logic        idle_en = 1'b0;

   logic [63:0] gen_state [4];
   logic [63:0] pending_values [$];
   int unsigned mismatches = 0;
   int unsigned results_seen = 0;
   int unsigned kind_count [4] = '{0, 0, 0, 0};
   int unsigned stall_left = 0;

   stim_row_type dir_table [DIR_COUNT];

   xoshiro256pp_random_generator_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_seed_value (req_seed_value),
      .req_bound      (req_bound),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Generator model
   // ------------------------------------------------------------------------

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned k);
      return (v << k) | (v >> (64 - k));
   endfunction

   // Fill the four words with successive splitmix64 outputs.
   function automatic void plant_seed(input logic [63:0] seed);
      logic [63:0] z;
      logic [63:0] m;
      z = seed;
      for (int i = 0; i < 4; i++) begin
         z = z + GOLDEN_GAMMA;
         m = z;
         m = (m ^ (m >> MIX_SHIFT_A)) * MIX_MUL_A;
         m = (m ^ (m >> MIX_SHIFT_B)) * MIX_MUL_B;
         gen_state[i] = m ^ (m >> MIX_SHIFT_C);
      end
   endfunction

   // Produce one xoshiro256++ output and step the words.
   function automatic logic [63:0] advance_state();
      logic [63:0] sum;
      logic [63:0] draw;
      logic [63:0] t;
      sum = gen_state[0] + gen_state[3];
      draw = rotl64(sum, ROT_OUT) + gen_state[0];
      t = gen_state[1] << SHIFT_T;
      gen_state[2] = gen_state[2] ^ gen_state[0];
      gen_state[3] = gen_state[3] ^ gen_state[1];
      gen_state[1] = gen_state[1] ^ gen_state[2];
      gen_state[0] = gen_state[0] ^ gen_state[3];
      gen_state[2] = gen_state[2] ^ t;
      gen_state[3] = rotl64(gen_state[3], ROT_STATE);
      return draw;
   endfunction

   // Expected response value of one request; updates the model state.
   function automatic logic [63:0] predict_value(input logic [1:0] kind,
                                                 input logic [63:0] seed,
                                                 input logic [31:0] bnd);
      logic [63:0] draw;
      logic [63:0] prod;
      case (kind)
         REQ_SEED: begin
            plant_seed(seed);
            return '0;
         end
         REQ_RAW: begin
            return advance_state();
         end
         REQ_BOUNDED: begin
            draw = advance_state();
            prod = {32'b0, draw[63:32]} * {32'b0, bnd};
            return {32'b0, prod[63:32]};
         end
         default: begin
            draw = advance_state();
            return draw >> FRAC_DROP;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatches < PRINT_CAP)
         $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor: predicts at each request transfer, checks each result transfer.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [63:0] want;
      if (reset) begin
         plant_seed(64'h0);
         pending_values.delete();
      end else begin
         if (req_valid && !req_stall) begin
            want = predict_value(req_type, req_seed_value, req_bound);
            if (row_fixed)
               want = row_value;
            pending_values.push_back(want);
            kind_count[req_type]++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_values.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_value, 64'h0);
            end else begin
               want = pending_values.pop_front();
               if (rsp_value !== want)
                  report_mismatch("value", rsp_value, want);
            end
         end
      end
   end

   // Receiver side: stall in bursts of random length.
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one request, after an optional idle burst, and wait for its
   // transfer. Returns in the time step of the accepting edge.
   task automatic send_request(input logic [1:0] kind, input logic [63:0] seed,
                               input logic [31:0] bnd, input logic fixed,
                               input logic [63:0] fval);
      int unsigned gap;
      if (idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_seed_value <= seed;
      req_bound      <= bnd;
      row_fixed      <= fixed;
      row_value      <= fval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Random request: mostly draws, now and then a reseed.
   task automatic send_random();
      logic [1:0]  kind;
      logic [63:0] seed;
      logic [31:0] bnd;
      if ($urandom_range(0, 15) == 0)
         kind = REQ_SEED;
      else
         kind = 2'($urandom_range(1, 3));
      case ($urandom_range(0, 7))
         0:       seed = 64'h0;
         1:       seed = '1;
         default: seed = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 7))
         0:       bnd = 32'h0;
         1:       bnd = '1;
         2, 3:    bnd = $urandom_range(1, 100);
         default: bnd = $urandom;
      endcase
      send_request(kind, seed, bnd, 1'b0, 64'h0);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      dir_table = '{
         // Draws straight after reset, from the zero-seeded state.
         '{REQ_RAW,     64'h0,                 32'h0,        1'b0, 64'h0},
         '{REQ_FRAC,    64'h0,                 32'h0,        1'b0, 64'h0},
         // Zero bound answers zero but still steps the state; a bound of one
         // can only give zero.
         '{REQ_BOUNDED, 64'h0,                 32'h0,        1'b1, 64'h0},
         '{REQ_BOUNDED, 64'h0,                 32'h1,        1'b1, 64'h0},
         '{REQ_BOUNDED, 64'h0,                 32'hffffffff, 1'b0, 64'h0},
         '{REQ_BOUNDED, 64'h0,                 32'h80000000, 1'b0, 64'h0},
         // Seeding answers zero.
         '{REQ_SEED,    64'h0,                 32'h0,        1'b1, 64'h0},
         '{REQ_RAW,     64'h0,                 32'h0,        1'b0, 64'h0},
         '{REQ_SEED,    64'hffffffffffffffff,  32'h0,        1'b1, 64'h0},
         '{REQ_RAW,     64'h0,                 32'h0,        1'b0, 64'h0},
         '{REQ_FRAC,    64'h0,                 32'h0,        1'b0, 64'h0},
         '{REQ_BOUNDED, 64'h0,                 32'd10,       1'b0, 64'h0},
         // Back-to-back seeds.
         '{REQ_SEED,    64'h0123456789abcdef,  32'h0,        1'b1, 64'h0},
         '{REQ_SEED,    64'hfedcba9876543210,  32'h0,        1'b1, 64'h0},
         // Unused fields at all ones must not matter.
         '{REQ_RAW,     64'hffffffffffffffff,  32'hffffffff, 1'b0, 64'h0},
         '{REQ_FRAC,    64'hffffffffffffffff,  32'hffffffff, 1'b0, 64'h0},
         '{REQ_BOUNDED, 64'hffffffffffffffff,  32'h0,        1'b1, 64'h0},
         '{REQ_SEED,    64'h8000000000000000,  32'hffffffff, 1'b1, 64'h0},
         '{REQ_BOUNDED, 64'h0,                 32'hffffffff, 1'b0, 64'h0},
         '{REQ_RAW,     64'h0,                 32'h0,        1'b0, 64'h0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, with idling so it also meets the reset seeding pass.
      idle_en <= 1'b1;
      for (int i = 0; i < DIR_COUNT; i++)
         send_request(dir_table[i].kind, dir_table[i].seed, dir_table[i].bound,
                      dir_table[i].fixed, dir_table[i].value);

      // Random part: idling switches on and off in stretches, off at the end.
      for (int i = 0; i < RAND_COUNT; i++) begin
         if (i >= RAND_COUNT - CALM_COUNT)
            idle_en <= 1'b0;
         else if (i % 50 == 0)
            idle_en <= ($urandom_range(0, 3) != 0);
         send_random();
      end
      req_valid <= 1'b0;
      row_fixed <= 1'b0;

      // Drain, then leave room for a stray result after a seed.
      while (pending_values.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Covered %0d seeds, %0d raw, %0d bounded and %0d fraction requests;",
               kind_count[REQ_SEED], kind_count[REQ_RAW], kind_count[REQ_BOUNDED],
               kind_count[REQ_FRAC]);
      $display("%0d results checked, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10_000_000;
      $display("Timeout with %0d results still pending.", pending_values.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
